// File: src/tbl_pkg.sv
// ----------------------------------------------------------------------------
// Token bucket limiter package
// Shared sizes, codes and types of the per-source token bucket limiter.
// ----------------------------------------------------------------------------
package tbl_pkg;

	localparam int TABLE_ENTRIES = 512;
	localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

	localparam int LEN_W = 16;
	localparam int KEY_W = 48;
	localparam int TIME_W = 64;
	localparam int TOK_W = 20;
	localparam int IVL_W = 40;
	localparam int CTR_W = 32;
	localparam logic [LEN_W-1:0] ETH_HEADER_BYTES = 16'd14;

	localparam logic [3:0] ADDR_BUCKET = 4'h0;
	localparam logic [3:0] ADDR_INTERVAL = 4'h8;

	typedef enum logic [2:0] {
		OUT_PASS_KNOWN = 3'd0,
		OUT_PASS_NEW = 3'd1,
		OUT_PASS_FULL = 3'd2,
		OUT_DROP_SHORT = 3'd3,
		OUT_DROP_LIMIT = 3'd4
	} outcome_t;

	typedef struct packed {
		logic done;
		logic hit;
		logic [IDX_W-1:0] idx;
	} search_res_t;

	typedef struct packed {
		logic [TOK_W-1:0] tokens;
		logic [TIME_W-1:0] stamp;
		logic [CTR_W-1:0] pass_count;
		logic [CTR_W-1:0] drop_count;
	} slot_t;

endpackage

// File: src/per_source_token_bucket_limiter_core.sv
// ----------------------------------------------------------------------------
// Per-source token bucket limiter core
// A short frame gives its result in the cycle after start; otherwise a search
// over the filled slots comes first, and a hit adds the read and update states.
// One transaction at a time, with the key memory scanned one slot per cycle.
// Reset empties the table at once through the fill count; results cannot stall.
// ----------------------------------------------------------------------------
module per_source_token_bucket_limiter_core (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  logic [tbl_pkg::LEN_W-1:0] frame_length,
	input  logic [tbl_pkg::KEY_W-1:0] source_address,
	input  logic [tbl_pkg::TIME_W-1:0] now_ns,
	output logic result_valid,
	output logic frame_passes,
	output logic [2:0] outcome,
	output logic [tbl_pkg::TOK_W-1:0] tokens_left,
	output logic [tbl_pkg::CTR_W-1:0] packets_passed,
	output logic [tbl_pkg::CTR_W-1:0] packets_dropped,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [3:0] paddr,
	input  logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic pready
);

	typedef enum logic [1:0] {ST_IDLE, ST_SEARCH, ST_READ, ST_UPD} state_t;

	state_t state_q;
	logic [tbl_pkg::TOK_W-1:0] bucket_q;
	logic [tbl_pkg::IVL_W-1:0] interval_q;
	logic [tbl_pkg::KEY_W-1:0] key_q;
	logic [tbl_pkg::TIME_W-1:0] now_q;
	logic [tbl_pkg::CNT_W-1:0] fill_q;
	logic [tbl_pkg::IDX_W-1:0] hit_idx_q;
	tbl_pkg::slot_t data_mem [tbl_pkg::TABLE_ENTRIES];
	tbl_pkg::slot_t rd_s1;
	tbl_pkg::slot_t new_slot;
	tbl_pkg::slot_t upd_slot;
	tbl_pkg::search_res_t srch;
	logic accept;
	logic go;
	logic insert;
	logic full;
	logic d_wr_en;
	logic [tbl_pkg::IDX_W-1:0] d_wr_addr;
	tbl_pkg::slot_t d_wr_data;
	logic [tbl_pkg::TIME_W-1:0] elapsed;
	logic refill;
	logic limit_drop;
	logic [tbl_pkg::TOK_W-1:0] tok_mid;
	logic cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;
	assign prdata = (paddr == tbl_pkg::ADDR_INTERVAL) ? {24'd0, interval_q} :
		(paddr == tbl_pkg::ADDR_BUCKET) ? {44'd0, bucket_q} : 64'd0;

	assign busy = (state_q != ST_IDLE);
	assign accept = start && !busy;
	assign go = accept && (frame_length >= tbl_pkg::ETH_HEADER_BYTES);
	assign full = (fill_q == tbl_pkg::CNT_W'(tbl_pkg::TABLE_ENTRIES));
	assign insert = (state_q == ST_SEARCH) && srch.done && !srch.hit && !full;

	tbl_search u_search (
		.clk     (clk),
		.arst_n  (arst_n),
		.go      (go),
		.key     (key_q),
		.fill    (fill_q),
		.wr_en   (insert),
		.wr_addr (fill_q[tbl_pkg::IDX_W-1:0]),
		.wr_key  (key_q),
		.res     (srch)
	);

	always_comb begin
		new_slot.tokens = bucket_q;
		new_slot.stamp = now_q;
		new_slot.pass_count = tbl_pkg::CTR_W'(1);
		new_slot.drop_count = '0;

		elapsed = now_q - rd_s1.stamp;
		refill = (rd_s1.tokens == '0) && (elapsed > {24'd0, interval_q});
		limit_drop = (rd_s1.tokens == '0) && !refill;
		tok_mid = refill ? bucket_q : rd_s1.tokens;
		upd_slot = rd_s1;
		if (refill) begin
			upd_slot.stamp = now_q;
		end
		if (limit_drop) begin
			upd_slot.drop_count = rd_s1.drop_count + 1'b1;
		end else begin
			upd_slot.tokens = (tok_mid != '0) ? tok_mid - 1'b1 : tok_mid;
			upd_slot.pass_count = rd_s1.pass_count + 1'b1;
		end

		d_wr_en = insert || (state_q == ST_UPD);
		d_wr_addr = insert ? fill_q[tbl_pkg::IDX_W-1:0] : hit_idx_q;
		d_wr_data = insert ? new_slot : upd_slot;
	end

	always_ff @(posedge clk) begin
		if (d_wr_en) begin
			data_mem[d_wr_addr] <= d_wr_data;
		end
		rd_s1 <= data_mem[hit_idx_q];
		if (accept) begin
			key_q <= source_address;
			now_q <= now_ns;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bucket_q <= tbl_pkg::TOK_W'(50000);
			interval_q <= tbl_pkg::IVL_W'(64'd5000000000);
		end else if (cfg_wr) begin
			if (paddr == tbl_pkg::ADDR_INTERVAL) begin
				interval_q <= pwdata[tbl_pkg::IVL_W-1:0];
			end else if (paddr == tbl_pkg::ADDR_BUCKET) begin
				bucket_q <= pwdata[tbl_pkg::TOK_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			fill_q <= '0;
			hit_idx_q <= '0;
			result_valid <= 1'b0;
			frame_passes <= 1'b0;
			outcome <= '0;
			tokens_left <= '0;
			packets_passed <= '0;
			packets_dropped <= '0;
		end else begin
			result_valid <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (go) begin
							state_q <= ST_SEARCH;
						end else begin
							result_valid <= 1'b1;
							frame_passes <= 1'b0;
							outcome <= tbl_pkg::OUT_DROP_SHORT;
							tokens_left <= '0;
							packets_passed <= '0;
							packets_dropped <= '0;
						end
					end
				end
				ST_SEARCH: begin
					if (srch.done) begin
						if (srch.hit) begin
							hit_idx_q <= srch.idx;
							state_q <= ST_READ;
						end else begin
							state_q <= ST_IDLE;
							result_valid <= 1'b1;
							frame_passes <= 1'b1;
							if (full) begin
								outcome <= tbl_pkg::OUT_PASS_FULL;
								tokens_left <= '0;
								packets_passed <= '0;
								packets_dropped <= '0;
							end else begin
								fill_q <= fill_q + 1'b1;
								outcome <= tbl_pkg::OUT_PASS_NEW;
								tokens_left <= bucket_q;
								packets_passed <= tbl_pkg::CTR_W'(1);
								packets_dropped <= '0;
							end
						end
					end
				end
				ST_READ: begin
					state_q <= ST_UPD;
				end
				ST_UPD: begin
					state_q <= ST_IDLE;
					result_valid <= 1'b1;
					frame_passes <= !limit_drop;
					outcome <= limit_drop ? tbl_pkg::OUT_DROP_LIMIT : tbl_pkg::OUT_PASS_KNOWN;
					tokens_left <= upd_slot.tokens;
					packets_passed <= upd_slot.pass_count;
					packets_dropped <= upd_slot.drop_count;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

`ifndef ASSERT_OFF
	a_strobe_cause: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> $past(start || busy)) else $error("result without transaction");
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= tbl_pkg::CNT_W'(tbl_pkg::TABLE_ENTRIES)) else $error("fill overflow");
	a_done_in_search: assert property (@(posedge clk) disable iff (!arst_n)
		srch.done |-> state_q == ST_SEARCH) else $error("search done outside search");
	a_upd_result: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_UPD |=> result_valid) else $error("update gave no result");
`endif

endmodule

// File: src/tbl_search.sv
// ----------------------------------------------------------------------------
// Source address search
// Holds the key memory and scans the filled slots for a matching address.
// ----------------------------------------------------------------------------
module tbl_search (
	input  logic clk,
	input  logic arst_n,
	input  logic go,
	input  logic [tbl_pkg::KEY_W-1:0] key,
	input  logic [tbl_pkg::CNT_W-1:0] fill,
	input  logic wr_en,
	input  logic [tbl_pkg::IDX_W-1:0] wr_addr,
	input  logic [tbl_pkg::KEY_W-1:0] wr_key,
	output tbl_pkg::search_res_t res
);

	logic [tbl_pkg::KEY_W-1:0] key_mem [tbl_pkg::TABLE_ENTRIES];
	logic [tbl_pkg::KEY_W-1:0] rd_s1;
	logic [tbl_pkg::IDX_W-1:0] addr_s1;
	logic [tbl_pkg::CNT_W-1:0] idx_q;
	logic pend_s1;
	logic active_q;
	logic match;
	logic more;

	assign more = idx_q < fill;
	assign match = pend_s1 && (rd_s1 == key);
	assign res.done = active_q && (match || (!pend_s1 && !more));
	assign res.hit = match;
	assign res.idx = addr_s1;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			key_mem[wr_addr] <= wr_key;
		end
		rd_s1 <= key_mem[idx_q[tbl_pkg::IDX_W-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			pend_s1 <= 1'b0;
			idx_q <= '0;
			addr_s1 <= '0;
		end else if (go) begin
			active_q <= 1'b1;
			pend_s1 <= 1'b0;
			idx_q <= '0;
		end else if (active_q) begin
			if (res.done) begin
				active_q <= 1'b0;
				pend_s1 <= 1'b0;
			end else begin
				pend_s1 <= more;
				if (more) begin
					idx_q <= idx_q + 1'b1;
					addr_s1 <= idx_q[tbl_pkg::IDX_W-1:0];
				end
			end
		end
	end

`ifndef ASSERT_OFF
	a_idx_bound: assert property (@(posedge clk) disable iff (!arst_n)
		idx_q <= fill || !active_q) else $error("scan ran past filled slots");
	a_done_once: assert property (@(posedge clk) disable iff (!arst_n)
		res.done |=> !active_q) else $error("search stayed active after done");
	a_hit_done: assert property (@(posedge clk) disable iff (!arst_n)
		(res.hit && active_q) |-> res.done) else $error("hit without done");
`endif

endmodule
